FILE: hdl/jhtd_pkg.sv
package jhtd_pkg;

  localparam int unsigned NUM_LENGTHS  = 16;
  localparam int unsigned MAX_CODE_LEN = 16;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_BIT   = 2'd2;

  localparam logic [1:0] K_SYMBOL = 2'd0;
  localparam logic [1:0] K_LOADED = 2'd1;
  localparam logic [1:0] K_BAD    = 2'd2;
  localparam logic [1:0] K_TERR   = 2'd3;

  typedef struct packed {
    logic [7:0]  cnt;
    logic [16:0] fc;
  } len_ent_t;

endpackage

FILE: hdl/jhtd_len_tbl.sv
module jhtd_len_tbl #(
  parameter int unsigned FIW = 9
) (
  input  logic                clk,
  input  logic                we,
  input  logic [3:0]          waddr,
  input  jhtd_pkg::len_ent_t  wdata,
  input  logic [FIW-1:0]      wfi,
  input  logic [3:0]          raddr,
  output jhtd_pkg::len_ent_t  rdata,
  output logic [FIW-1:0]      rfi,
  output logic [15:0]         nz
);
  import jhtd_pkg::*;

  len_ent_t       ent_r [NUM_LENGTHS];
  logic [FIW-1:0] fi_r  [NUM_LENGTHS];
  logic [15:0]    nz_r;

  always_ff @(posedge clk) begin
    if (we) begin
      ent_r[waddr] <= wdata;
      fi_r[waddr]  <= wfi;
      nz_r[waddr]  <= (wdata.cnt != 8'd0);
    end
  end

  assign rdata = ent_r[raddr];
  assign rfi   = fi_r[raddr];
  assign nz    = nz_r;

endmodule

FILE: hdl/jpeg_huffman_table_decoder_unit.sv
// Channel | Ports        | tuser (low bit up) | tdata (low bit up)
// in      | in_t*        | command[1:0]       | data_byte[7:0], code_bit[8], zero[15:9]
// out     | out_t*       | kind[1:0]          | symbol[7:0], code_length[12:8],
//         |              |                    | bytes_read[21:13], zero[23:22]
//
// One word per cycle in while in_tready is high; each result word leaves in the cycle after its input word,
// set by the registered read of the symbol RAM into the output register.
// Reset leaves the table invalid; table storage is not cleared.
// in_tready drops only while a result word is held and out_tready is low.
module jpeg_huffman_table_decoder_unit #(
  parameter int unsigned MAX_SYMBOLS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte, code_bit
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // symbol, code_length, bytes_read
  output logic [1:0]  out_tuser   // kind
);
  import jhtd_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SYMBOLS);
  localparam int unsigned SCW = $clog2(MAX_SYMBOLS + 1);

  typedef enum logic [1:0] {PH_IDLE, PH_COUNTS, PH_SYMBOLS} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [3:0]    li_r, li_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [16:0]   ncode_r, ncode_nxt;
  logic [SCW-1:0] sc_r, sc_nxt;
  logic [8:0]    bc_r, bc_nxt;
  logic          valid_r, valid_nxt;
  logic [15:0]   acc_r, acc_nxt;
  logic [4:0]    bg_r, bg_nxt;
  logic [4:0]    longest_r, longest_nxt;
  logic [15:0]   last_r, last_nxt;
  logic [16:0]   run_code_r, run_code_nxt;
  logic [SCW-1:0] run_idx_r, run_idx_nxt;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [4:0]    out_len_r;
  logic [8:0]    out_bytes_r;

  logic [7:0]    ram_r [MAX_SYMBOLS];
  logic [7:0]    ram_q_r;

  logic          adv;
  logic [1:0]    cmd;
  logic [7:0]    dbyte;
  logic          cbit;

  logic          emit;
  logic [1:0]    ekind;
  logic [4:0]    elen;
  logic [8:0]    ebytes;
  logic          ram_we;
  logic          rd_en;
  logic [AW-1:0] ridx;

  logic          tbl_we;
  len_ent_t      tbl_wdata;
  logic [3:0]    tbl_raddr;
  len_ent_t      tbl_rdata;
  logic [SCW-1:0] tbl_rfi;
  logic [15:0]   nz;

  logic [15:0]   nz_fwd;
  logic          first_found;
  logic [3:0]    first_idx;
  logic          next_found;
  logic [3:0]    next_idx;

  logic [15:0]   acc_n;
  logic [4:0]    bg_n;
  logic [16:0]   diff;
  logic          match;
  logic          bad;
  logic [SCW+8:0] idx_sum;
  logic [17:0]   code_sum;
  logic [SCW+7:0] cnt_sum;
  logic [4:0]    len;
  logic          sym_err;

  jhtd_len_tbl #(.FIW(SCW)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (li_r),
    .wdata (tbl_wdata),
    .wfi   (run_idx_r),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata),
    .rfi   (tbl_rfi),
    .nz    (nz)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign adv       = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign dbyte     = in_tdata[7:0];
  assign cbit      = in_tdata[8];

  assign tbl_wdata.cnt = dbyte;
  assign tbl_wdata.fc  = run_code_r;

  // lowest nonzero length, with the count arriving now forwarded
  always_comb begin
    nz_fwd      = {dbyte != 8'd0, nz[14:0]};
    first_found = 1'b0;
    first_idx   = 4'd0;
    for (int k = NUM_LENGTHS - 1; k >= 0; k--) begin
      if (nz_fwd[k]) begin
        first_found = 1'b1;
        first_idx   = 4'(k);
      end
    end
  end

  always_comb begin
    next_found = 1'b0;
    next_idx   = 4'd0;
    for (int k = NUM_LENGTHS - 1; k >= 0; k--) begin
      if (nz[k] && (4'(k) > li_r)) begin
        next_found = 1'b1;
        next_idx   = 4'(k);
      end
    end
  end

  always_comb begin
    acc_n   = {acc_r[14:0], cbit};
    bg_n    = bg_r + 5'd1;
    diff    = {1'b0, acc_n} - tbl_rdata.fc;
    match   = (bg_n <= 5'(NUM_LENGTHS)) && ({1'b0, acc_n} >= tbl_rdata.fc) &&
              (diff[16:8] == 9'd0) && (diff[7:0] < tbl_rdata.cnt);
    bad     = (bg_n >= longest_r) || (acc_n > (last_r >> (longest_r - bg_n)));
    idx_sum = (SCW+9)'(tbl_rfi) + (SCW+9)'(diff[7:0]);
    ridx    = idx_sum[AW-1:0];
    code_sum = {1'b0, run_code_r} + 18'(dbyte);
    cnt_sum  = (SCW+8)'(run_idx_r) + (SCW+8)'(dbyte);
    len      = {1'b0, li_r} + 5'd1;
    sym_err  = (len > 5'(MAX_CODE_LEN)) || (ncode_r >= (17'd1 << len)) ||
               (sc_r >= SCW'(MAX_SYMBOLS));
  end

  always_comb begin
    phase_nxt    = phase_r;
    li_nxt       = li_r;
    rem_nxt      = rem_r;
    ncode_nxt    = ncode_r;
    sc_nxt       = sc_r;
    bc_nxt       = bc_r;
    valid_nxt    = valid_r;
    acc_nxt      = acc_r;
    bg_nxt       = bg_r;
    longest_nxt  = longest_r;
    last_nxt     = last_r;
    run_code_nxt = run_code_r;
    run_idx_nxt  = run_idx_r;
    emit         = 1'b0;
    ekind        = K_BAD;
    elen         = 5'd0;
    ebytes       = 9'd0;
    ram_we       = 1'b0;
    rd_en        = 1'b0;
    tbl_we       = 1'b0;
    tbl_raddr    = bg_r[3:0];

    if (adv) begin
      case (cmd)
        CMD_BEGIN: begin
          valid_nxt    = 1'b0;
          phase_nxt    = PH_COUNTS;
          li_nxt       = 4'd0;
          rem_nxt      = 8'd0;
          ncode_nxt    = 17'd0;
          sc_nxt       = '0;
          bc_nxt       = 9'd0;
          longest_nxt  = 5'd0;
          last_nxt     = 16'd0;
          acc_nxt      = 16'd0;
          bg_nxt       = 5'd0;
          run_code_nxt = 17'd0;
          run_idx_nxt  = '0;
        end
        CMD_BYTE: begin
          case (phase_r)
            PH_COUNTS: begin
              tbl_we       = 1'b1;
              bc_nxt       = bc_r + 9'd1;
              run_code_nxt = {code_sum[15:0], 1'b0};
              run_idx_nxt  = cnt_sum[SCW-1:0];
              li_nxt       = li_r + 4'd1;
              if (li_r == 4'(NUM_LENGTHS - 1)) begin
                tbl_raddr = first_idx;
                if (!first_found) begin
                  phase_nxt = PH_IDLE;
                  valid_nxt = 1'b1;
                  acc_nxt   = 16'd0;
                  bg_nxt    = 5'd0;
                  emit      = 1'b1;
                  ekind     = K_LOADED;
                  ebytes    = bc_r + 9'd1;
                end else begin
                  phase_nxt = PH_SYMBOLS;
                  li_nxt    = first_idx;
                  if (first_idx == li_r) begin
                    rem_nxt   = dbyte;
                    ncode_nxt = run_code_r;
                  end else begin
                    rem_nxt   = tbl_rdata.cnt;
                    ncode_nxt = tbl_rdata.fc;
                  end
                end
              end
            end
            PH_SYMBOLS: begin
              bc_nxt = bc_r + 9'd1;
              if (sym_err) begin
                phase_nxt = PH_IDLE;
                valid_nxt = 1'b0;
                emit      = 1'b1;
                ekind     = K_TERR;
              end else begin
                ram_we      = 1'b1;
                last_nxt    = ncode_r[15:0];
                longest_nxt = len;
                ncode_nxt   = ncode_r + 17'd1;
                sc_nxt      = sc_r + SCW'(1);
                rem_nxt     = rem_r - 8'd1;
                if (rem_r == 8'd1) begin
                  tbl_raddr = next_idx;
                  if (!next_found) begin
                    phase_nxt = PH_IDLE;
                    valid_nxt = 1'b1;
                    acc_nxt   = 16'd0;
                    bg_nxt    = 5'd0;
                    emit      = 1'b1;
                    ekind     = K_LOADED;
                    ebytes    = bc_r + 9'd1;
                  end else begin
                    li_nxt    = next_idx;
                    rem_nxt   = tbl_rdata.cnt;
                    ncode_nxt = tbl_rdata.fc;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_BIT: begin
          if (!valid_r) begin
            acc_nxt = 16'd0;
            bg_nxt  = 5'd0;
            emit    = 1'b1;
            ekind   = K_BAD;
          end else if (match) begin
            acc_nxt = 16'd0;
            bg_nxt  = 5'd0;
            rd_en   = 1'b1;
            emit    = 1'b1;
            ekind   = K_SYMBOL;
            elen    = bg_n;
          end else if (bad) begin
            acc_nxt = 16'd0;
            bg_nxt  = 5'd0;
            emit    = 1'b1;
            ekind   = K_BAD;
          end else begin
            acc_nxt = acc_n;
            bg_nxt  = bg_n;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_r[sc_r[AW-1:0]] <= dbyte;
    end
    if (rd_en) begin
      ram_q_r <= ram_r[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      li_r        <= 4'd0;
      rem_r       <= 8'd0;
      ncode_r     <= 17'd0;
      sc_r        <= '0;
      bc_r        <= 9'd0;
      valid_r     <= 1'b0;
      acc_r       <= 16'd0;
      bg_r        <= 5'd0;
      longest_r   <= 5'd0;
      last_r      <= 16'd0;
      run_code_r  <= 17'd0;
      run_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      li_r       <= li_nxt;
      rem_r      <= rem_nxt;
      ncode_r    <= ncode_nxt;
      sc_r       <= sc_nxt;
      bc_r       <= bc_nxt;
      valid_r    <= valid_nxt;
      acc_r      <= acc_nxt;
      bg_r       <= bg_nxt;
      longest_r  <= longest_nxt;
      last_r     <= last_nxt;
      run_code_r <= run_code_nxt;
      run_idx_r  <= run_idx_nxt;
      if (in_tready) begin
        out_valid_r <= adv && emit;
        out_kind_r  <= ekind;
        out_len_r   <= elen;
        out_bytes_r <= ebytes;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {2'b00, out_bytes_r, out_len_r,
                       (out_kind_r == K_SYMBOL) ? ram_q_r : 8'd0};

endmodule

FILE: hdl/jhtd_chk.sv
module jhtd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import jhtd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_BEGIN |=> !out_tvalid)
    else $error("begin command produced a result");

  a_symbol_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_SYMBOL |->
      out_tdata[12:8] != 5'd0 && out_tdata[12:8] <= 5'd16)
    else $error("symbol result with bad code length");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_SYMBOL |-> out_tdata[12:0] == 13'd0)
    else $error("non-symbol result carries symbol or length");

endmodule

bind jpeg_huffman_table_decoder_unit jhtd_chk u_jhtd_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
